### hdl/gdd_pkg.sv
// ----------------------------------------------------------------------------
// gdd_pkg: shared types and constants for the Gregorian day difference
// Month tables, reciprocal constants and the stage-enable bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int SHIFT_W  = 15;   // year plus one 400-year cycle
	localparam int SERIAL_W = 23;
	localparam int COUNT_W  = 22;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 22'd3652060;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2**15
	localparam logic [SHIFT_W-1:0] RECIP_100   = 15'd20972;
	localparam int                 RECIP_SHIFT = 21;

	localparam logic [SHIFT_W-1:0] YEAR_BIAS  = 15'd399;
	localparam logic [8:0]         DAYS_YEAR  = 9'd365;
	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;

	// Stage advance enables handed to each lane
	typedef struct packed {
		logic s1;
		logic s2;
	} gdd_stage_en_t;

	// Length of a month, February stretched in a leap year
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
	                                              input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2:                                      len = leap ? 5'd29 : 5'd28;
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the year before the first of a month (common year)
	function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### hdl/gdd_lane.sv
// ----------------------------------------------------------------------------
// gdd_lane: one date to serial day number
// Two stages: reciprocal products, then leap test, range check and day sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdd_lane import gdd_pkg::*; (
	input  wire                  clk,
	input  wire gdd_stage_en_t   en,
	input  wire [DAY_W-1:0]      day,
	input  wire [MONTH_W-1:0]    month,
	input  wire [YEAR_W-1:0]     year,
	output logic [SERIAL_W-1:0]  serial,
	output logic                 ok
);

	logic [SHIFT_W-1:0]          yy;
	logic [YEAR_W+SHIFT_W-1:0]   py;
	logic [2*SHIFT_W-1:0]        pyy;
	logic [SHIFT_W-3:0]          q4;
	logic [2*SHIFT_W-3:0]        pq4;
	logic [SERIAL_W:0]           p365;

	logic [7:0]                  qy100_s1;
	logic [YEAR_W-1:0]           year_s1;
	logic [DAY_W-1:0]            day_s1;
	logic [MONTH_W-1:0]          month_s1;
	logic [SERIAL_W-1:0]         p365_s1;
	logic [SHIFT_W-3:0]          q4_s1;
	logic [8:0]                  q100_s1;
	logic [6:0]                  q400_s1;

	logic [YEAR_W-1:0]           hundreds;
	logic                        leap;
	logic                        ok_c;
	logic [SERIAL_W-1:0]         serial_c;
	logic [SERIAL_W-1:0]         serial_s2;
	logic                        ok_s2;

	// Form reciprocal and year products
	always_comb begin
		yy   = SHIFT_W'(year) + YEAR_BIAS;
		py   = year * RECIP_100;
		pyy  = yy * RECIP_100;
		q4   = yy[SHIFT_W-1:2];
		pq4  = q4 * RECIP_100;
		p365 = yy * DAYS_YEAR;
	end

	// Hold products for the sum stage
	always_ff @(posedge clk) begin
		if (en.s1) begin
			qy100_s1 <= py[RECIP_SHIFT+7:RECIP_SHIFT];
			year_s1  <= year;
			day_s1   <= day;
			month_s1 <= month;
			p365_s1  <= p365[SERIAL_W-1:0];
			q4_s1    <= q4;
			q100_s1  <= pyy[RECIP_SHIFT+8:RECIP_SHIFT];
			q400_s1  <= pq4[RECIP_SHIFT+6:RECIP_SHIFT];
		end
	end

	// Test leap year and range, add up the serial day
	always_comb begin
		hundreds = YEAR_W'(qy100_s1) * YEAR_W'(100);
		leap     = (year_s1[1:0] == 2'd0) &&
		           ((year_s1 != hundreds) || (qy100_s1[1:0] == 2'd0));
		ok_c     = (month_s1 != '0) && (month_s1 <= MONTH_DEC) && (day_s1 != '0) &&
		           (day_s1 <= month_len(month_s1, leap));
		serial_c = p365_s1 + SERIAL_W'(q4_s1) - SERIAL_W'(q100_s1) + SERIAL_W'(q400_s1)
		         + SERIAL_W'(days_before(month_s1))
		         + SERIAL_W'((month_s1 > MONTH_FEB) && leap) + SERIAL_W'(day_s1);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			serial_s2 <= serial_c;
			ok_s2     <= ok_c;
		end
	end

	assign serial = serial_s2;
	assign ok     = ok_s2;

endmodule

`default_nettype wire

### hdl/gdd_merge.sv
// ----------------------------------------------------------------------------
// gdd_merge: combine both lanes into the day count
// Difference, end-day adjust, saturation and error zeroing into the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdd_merge import gdd_pkg::*; (
	input  wire                  clk,
	input  wire                  en,
	input  wire [SERIAL_W-1:0]   start_serial,
	input  wire [SERIAL_W-1:0]   end_serial,
	input  wire                  start_ok,
	input  wire                  end_ok,
	input  wire                  include_end_day,
	output logic [COUNT_W-1:0]   day_count,
	output logic                 date_error
);

	logic [SERIAL_W:0]    diff;
	logic [COUNT_W-1:0]   count_c;
	logic                 err_c;
	logic [COUNT_W-1:0]   count_s3;
	logic                 err_s3;

	// Subtract, adjust and clamp
	always_comb begin
		err_c = !(start_ok && end_ok);
		diff  = (start_serial < end_serial) ?
		        (SERIAL_W+1)'(end_serial - start_serial) : '0;
		diff  = diff + (SERIAL_W+1)'(include_end_day);
		if (err_c) begin
			count_c = '0;
		end else if (diff > (SERIAL_W+1)'(COUNT_MAX)) begin
			count_c = COUNT_MAX;
		end else begin
			count_c = diff[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			count_s3 <= count_c;
			err_s3   <= err_c;
		end
	end

	assign day_count  = count_s3;
	assign date_error = err_s3;

endmodule

`default_nettype wire

### hdl/gregorian_day_difference.sv
// ----------------------------------------------------------------------------
// gregorian_day_difference: days between two Gregorian dates
// Two date lanes feed a merge stage; three-stage pipeline with stall.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata: two dates, tuser: include_end_day
// m_axis    out  m_axis_tvalid/tready   tdata: day_count, tuser: date_error
//
// One request per cycle unless the output stalls while every stage is full.
// The depth is set by the lane products, the serial sum and the merge register.
// Each stage advances when it or any stage after it is empty, so bubbles close.
// Reset clears only the stage valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gregorian_day_difference import gdd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	// start_day[4:0], start_month[8:5], start_year[22:9], end_day[27:23],
	// end_month[31:28], end_year[45:32], zero pad[47:46]
	input  wire [47:0]  s_axis_tdata,
	// include_end_day[0]
	input  wire [0:0]   s_axis_tuser,
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	// day_count[21:0], zero pad[23:22]
	output logic [23:0] m_axis_tdata,
	// date_error[0]
	output logic [0:0]  m_axis_tuser
);

	gdd_stage_en_t        en;
	logic                 en3;
	logic                 v1_q, v2_q, v3_q;
	logic                 inc_s1, inc_s2;
	logic [SERIAL_W-1:0]  start_serial, end_serial;
	logic                 start_ok, end_ok;
	logic [COUNT_W-1:0]   day_count;
	logic                 date_error;

	// Advance each stage when it is empty or the next one moves
	assign en3           = !v3_q || m_axis_tready;
	assign en.s2         = !v2_q || en3;
	assign en.s1         = !v1_q || en.s2;
	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (en.s1) v1_q <= s_axis_tvalid;
			if (en.s2) v2_q <= v1_q;
			if (en3)   v3_q <= v2_q;
		end
	end

	// Carry the end-day flag beside the lanes
	always_ff @(posedge clk) begin
		if (en.s1) inc_s1 <= s_axis_tuser[0];
		if (en.s2) inc_s2 <= inc_s1;
	end

	gdd_lane u_start_lane (
		.clk    (clk),
		.en     (en),
		.day    (s_axis_tdata[4:0]),
		.month  (s_axis_tdata[8:5]),
		.year   (s_axis_tdata[22:9]),
		.serial (start_serial),
		.ok     (start_ok)
	);

	gdd_lane u_end_lane (
		.clk    (clk),
		.en     (en),
		.day    (s_axis_tdata[27:23]),
		.month  (s_axis_tdata[31:28]),
		.year   (s_axis_tdata[45:32]),
		.serial (end_serial),
		.ok     (end_ok)
	);

	gdd_merge u_merge (
		.clk             (clk),
		.en              (en3),
		.start_serial    (start_serial),
		.end_serial      (end_serial),
		.start_ok        (start_ok),
		.end_ok          (end_ok),
		.include_end_day (inc_s2),
		.day_count       (day_count),
		.date_error      (date_error)
	);

	assign m_axis_tvalid = v3_q;
	assign m_axis_tdata  = {2'b00, day_count};
	assign m_axis_tuser  = date_error;

	// An error result always carries a zero count
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && date_error |-> day_count == '0)
		else $error("error result with nonzero count");

	// Count never passes the saturation limit
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> day_count <= COUNT_MAX)
		else $error("count above limit");

	// An empty output stage never blocks new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// A request taken into a free pipe moves through each stage to the output
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !v1_q && !v2_q && !v3_q |=> ##1 ##1 m_axis_tvalid)
		else $error("request lost in pipeline");

endmodule

`default_nettype wire

### dv/tb_gregorian_day_difference.sv
// ----------------------------------------------------------------------------
// tb_gregorian_day_difference: self-checking bench for the day difference
// Walks a table of directed date pairs, then about 900 random requests, with
// random gaps on both streams and one long output hold-off. Every result is
// checked in order, against a typed table value or a behavioral date predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gregorian_day_difference;
	import gdd_pkg::*;

	localparam int N_RANDOM     = 900;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int TAIL_CYCLES  = 12;

	// Random date flavors
	localparam int GEN_SPAN  = 0;   // valid, year 1..9999
	localparam int GEN_WIDE  = 1;   // valid, any 14-bit year
	localparam int GEN_NEAR  = 2;   // valid, year next to a base year
	localparam int GEN_EDGE  = 3;   // last day of month or one past it
	localparam int GEN_RAW   = 4;   // raw field bits

	typedef struct packed {
		logic [DAY_W-1:0]   sd;
		logic [MONTH_W-1:0] sm;
		logic [YEAR_W-1:0]  sy;
		logic [DAY_W-1:0]   ed;
		logic [MONTH_W-1:0] em;
		logic [YEAR_W-1:0]  ey;
		logic               inc;
	} date_pair_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               err;
	} span_t;

	typedef struct {
		date_pair_t req;
		bit         typed;
		span_t      want;
	} table_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata  = '0;
	logic [0:0]  s_axis_tuser  = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	span_t      span_q[$];
	table_row_t dir_rows[$];
	span_t      head;
	int         errors    = 0;
	int         sent      = 0;
	int         checked   = 0;
	int         n_invalid = 0;
	int         n_sat     = 0;
	bit         tx_steady = 1'b0;
	bit         rx_steady = 1'b0;
	bit         hold_req  = 1'b0;

	gregorian_day_difference u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// ---------------- date predictor ----------------

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// Zero for a month outside 1..12, so any nonzero day fails against it
	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return is_leap(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic int unsigned days_ahead_of_month(input int unsigned m);
		case (m)
			2:       return 31;
			3:       return 59;
			4:       return 90;
			5:       return 120;
			6:       return 151;
			7:       return 181;
			8:       return 212;
			9:       return 243;
			10:      return 273;
			11:      return 304;
			12:      return 334;
			default: return 0;
		endcase
	endfunction

	function automatic bit date_valid(input int unsigned d, input int unsigned m,
	                                  input int unsigned y);
		return (d != 0) && (d <= month_days(m, y));
	endfunction

	// Day number, shifted by one 400-year cycle so year zero stays positive
	function automatic int unsigned day_serial(input int unsigned d, input int unsigned m,
	                                           input int unsigned y);
		int unsigned yy;
		yy = y + 399;
		return 365 * yy + yy / 4 - yy / 100 + yy / 400 + days_ahead_of_month(m)
		       + ((m > 2 && is_leap(y)) ? 1 : 0) + d;
	endfunction

	function automatic span_t days_between(input date_pair_t p);
		span_t       r;
		int unsigned a, b, n;
		r = '0;
		if (!date_valid(p.sd, p.sm, p.sy) || !date_valid(p.ed, p.em, p.ey)) begin
			r.err = 1'b1;
		end else begin
			a = day_serial(p.sd, p.sm, p.sy);
			b = day_serial(p.ed, p.em, p.ey);
			n = (a < b) ? (b - a) : 0;
			n += p.inc;
			if (n > COUNT_MAX)
				n = COUNT_MAX;
			r.count = n[COUNT_W-1:0];
		end
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------

	task automatic add_row(input int sd, input int sm, input int sy, input int ed,
	                       input int em, input int ey, input bit inc, input bit typed,
	                       input int count, input bit err);
		table_row_t row;
		row.req   = '{DAY_W'(sd), MONTH_W'(sm), YEAR_W'(sy), DAY_W'(ed), MONTH_W'(em),
		              YEAR_W'(ey), inc};
		row.typed = typed;
		row.want  = '{COUNT_W'(count), err};
		dir_rows.push_back(row);
	endtask

	task automatic pick_date(input int kind, input int base_y, output logic [DAY_W-1:0] d,
	                         output logic [MONTH_W-1:0] m, output logic [YEAR_W-1:0] y);
		int unsigned len;
		if (kind == GEN_RAW) begin
			d = DAY_W'($urandom);
			m = MONTH_W'($urandom);
			y = YEAR_W'($urandom);
		end else begin
			m = MONTH_W'($urandom_range(12, 1));
			case (kind)
				GEN_SPAN: y = YEAR_W'($urandom_range(9999, 1));
				GEN_WIDE: y = YEAR_W'($urandom_range(16383, 0));
				GEN_NEAR: y = YEAR_W'(base_y + $urandom_range(1, 0));
				default: begin
					// lean on February and century years
					if ($urandom_range(1, 0))
						m = 4'd2;
					y = YEAR_W'($urandom_range(1, 0) ? $urandom_range(163, 0) * 100
					                                 : $urandom_range(4095, 0) * 4);
				end
			endcase
			len = month_days(m, y);
			if (kind == GEN_EDGE)
				d = DAY_W'(len + $urandom_range(1, 0));
			else
				d = DAY_W'($urandom_range(len, 1));
		end
	endtask

	task automatic random_pair(output date_pair_t p);
		int         r;
		int         k_start, k_end;
		date_pair_t q;
		r = $urandom_range(99);
		if (r < 50) begin
			k_start = GEN_SPAN; k_end = GEN_SPAN;
		end else if (r < 65) begin
			k_start = GEN_SPAN; k_end = GEN_NEAR;
		end else if (r < 75) begin
			k_start = GEN_WIDE; k_end = GEN_WIDE;
		end else if (r < 88) begin
			k_start = $urandom_range(1, 0) ? GEN_EDGE : GEN_SPAN;
			k_end   = (k_start == GEN_EDGE) ? GEN_SPAN : GEN_EDGE;
		end else begin
			k_start = GEN_RAW;
			k_end   = $urandom_range(1, 0) ? GEN_RAW : GEN_SPAN;
		end
		pick_date(k_start, 0, q.sd, q.sm, q.sy);
		pick_date(k_end, q.sy, q.ed, q.em, q.ey);
		q.inc = 1'($urandom_range(1, 0));
		// put most pairs in forward order so counts are nonzero
		if (day_serial(q.sd, q.sm, q.sy) > day_serial(q.ed, q.em, q.ey)
		    && $urandom_range(4, 0) != 0) begin
			p = '{q.ed, q.em, q.ey, q.sd, q.sm, q.sy, q.inc};
		end else begin
			p = q;
		end
	endtask

	// Offer one request, wait for its handshake and queue its expected result
	task automatic offer(input date_pair_t p, input bit typed, input span_t want);
		if (!tx_steady && $urandom_range(99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, p.ey, p.em, p.ed, p.sy, p.sm, p.sd};
		s_axis_tuser  <= p.inc;
		do @(posedge clk); while (!s_axis_tready);
		span_q.push_back(typed ? want : days_between(p));
		sent++;
	endtask

	// ---------------- result side ----------------

	// Drive tready: random gaps, a steady stretch, and one long hold-off
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (rx_steady) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 9);
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (span_q.size() == 0) begin
				$error("unexpected result: day_count %0d date_error %0d",
				       m_axis_tdata[COUNT_W-1:0], m_axis_tuser[0]);
				errors++;
			end else begin
				head = span_q.pop_front();
				if (m_axis_tdata[COUNT_W-1:0] !== head.count) begin
					$error("day_count: expected %0d, got %0d", head.count,
					       m_axis_tdata[COUNT_W-1:0]);
					errors++;
				end
				if (m_axis_tuser[0] !== head.err) begin
					$error("date_error: expected %0d, got %0d", head.err, m_axis_tuser[0]);
					errors++;
				end
				if (head.err)
					n_invalid++;
				if (head.count == COUNT_MAX)
					n_sat++;
				checked++;
			end
		end
	end

	// ---------------- main sequence ----------------

	initial begin : stim
		date_pair_t p;
		int         wait_cyc;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sd sm sy   ed em ey   inc  typed count err
		add_row( 1,  1,     1, 31, 12,  9999, 0, 1, 3652058, 0);  // full 1..9999 span
		add_row( 1,  1,     1, 31, 12,  9999, 1, 1, 3652059, 0);
		add_row( 1,  1,     0, 31, 12, 16383, 1, 1, COUNT_MAX, 0); // saturates
		add_row( 1,  1,     1,  1,  1, 16383, 0, 0, 0, 0);
		add_row(31, 15, 16383, 31, 15, 16383, 1, 1, 0, 1);         // all fields at max
		add_row( 0,  0,     0,  0,  0,     0, 0, 1, 0, 1);         // all zero
		add_row(15,  6,  2020, 15,  6,  2020, 0, 1, 0, 0);         // same date
		add_row(15,  6,  2020, 15,  6,  2020, 1, 1, 1, 0);
		add_row( 1,  1,  2021,  1,  1,  2020, 0, 1, 0, 0);         // start after end
		add_row( 1,  1,  2021,  1,  1,  2020, 1, 1, 1, 0);
		add_row(31, 12,  1999,  1,  1,  2000, 0, 1, 1, 0);
		add_row(29,  2,  1900,  1,  3,  1900, 0, 1, 0, 1);         // no leap day in 1900
		add_row(29,  2,  2000,  1,  3,  2000, 0, 0, 0, 0);         // leap by 400 rule
		add_row(29,  2,     0,  1,  1,     1, 0, 0, 0, 0);         // year zero is leap
		add_row(31,  4,  2010,  1,  5,  2010, 0, 1, 0, 1);         // day past month end
		add_row( 1,  1,  2010,  0,  5,  2010, 1, 1, 0, 1);         // day zero
		add_row( 1, 13,  2010,  1,  1,  2011, 0, 1, 0, 1);         // month too big
		add_row( 1,  1,  2010,  1,  0,  2011, 0, 1, 0, 1);         // month zero
		add_row(31,  2,  2024,  1,  3,  2024, 1, 1, 0, 1);         // invalid, flag ignored
		add_row(28,  2,  2023,  1,  3,  2023, 0, 0, 0, 0);
		add_row( 1,  3,  2024,  1,  3,  2025, 0, 0, 0, 0);
		add_row( 1,  1,  1600,  1,  1,  2000, 1, 0, 0, 0);
		add_row(31, 12,  9999,  1,  1, 10000, 0, 0, 0, 0);         // past 9999
		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// random requests
		for (int n = 0; n < N_RANDOM; n++) begin
			tx_steady = (n >= 300 && n < 420);
			rx_steady = tx_steady;
			if (n == 600)
				hold_req = 1'b1;
			random_pair(p);
			offer(p, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
		rx_steady = 1'b0;

		// drain outstanding results
		wait_cyc = 0;
		while (span_q.size() != 0 && wait_cyc < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cyc++;
		end
		if (span_q.size() != 0) begin
			$error("%0d results never arrived", span_q.size());
			errors++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d date pairs (%0d directed), checked %0d results.",
		         sent, dir_rows.size(), checked);
		$display("Of those %0d were flagged invalid and %0d hit the count ceiling.",
		         n_invalid, n_sat);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### gregorian_day_difference.f
hdl/gdd_pkg.sv
hdl/gdd_lane.sv
hdl/gdd_merge.sv
hdl/gregorian_day_difference.sv
dv/tb_gregorian_day_difference.sv
